// ----- design/vertex_perspective_transform_unit_macros.svh -----
// Assertion macros for the vertex perspective transform unit.
`ifndef VERTEX_PERSPECTIVE_TRANSFORM_UNIT_MACROS_SVH
`define VERTEX_PERSPECTIVE_TRANSFORM_UNIT_MACROS_SVH

// Check that holds at every edge outside reset.
`define VPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check in the cycle after the antecedent.
`define VPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/vpt_pkg.sv -----
// Shared widths, types, codes and helpers of the vertex perspective transform unit.
package vpt_pkg;

	localparam int AX_W    = 16;
	localparam int CO_W    = 24;
	localparam int OFS_W   = 12;
	localparam int MODE_W  = 2;
	localparam int ROW_W   = 2;
	localparam int NROW    = 3;

	localparam int PF_W    = 2 * AX_W;
	localparam int DIF_W   = CO_W + 1;
	localparam int PA_W    = DIF_W + AX_W;
	localparam int F_W     = PF_W + 2;
	localparam int ADD_W   = PA_W + 2;
	localparam int ACC_W   = F_W + CO_W;
	localparam int SHIFT   = 16;
	localparam int V_W     = ACC_W - SHIFT;

	localparam int DIV_NUM_W = 52;
	localparam int DIV_DEN_W = 42;

	localparam int AXIS_FRAC   = 14;
	localparam int PROJ_SH_HI  = 9;
	localparam int PROJ_SH_LO  = 7;
	localparam int SCREEN_Y_CENTRE = 240;
	localparam int DEPTH_SCALE = 10;
	localparam int DEPTH_SHIFT = 36;
	localparam int VZ_ONE_SH   = 20;

	localparam logic [OFS_W-1:0] VIEW_OFFSET_RESET = OFS_W'(320);
	localparam logic signed [AX_W-1:0] AXIS_ONE = AX_W'(16384);

	typedef enum logic [MODE_W-1:0] {
		MODE_CAM    = 2'd0,
		MODE_OBJ    = 2'd1,
		MODE_VERTEX = 2'd2,
		MODE_IGNORE = 2'd3
	} mode_t;

	typedef logic signed [AX_W-1:0]  axis_t;
	typedef logic signed [CO_W-1:0]  coord_t;
	typedef logic signed [F_W-1:0]   fent_t;
	typedef logic signed [ADD_W-1:0] addv_t;
	typedef logic signed [V_W-1:0]   view_t;

	function automatic axis_t sat_axis(input coord_t v);
		axis_t r;
		if (v > coord_t'(32767))
			r = AX_W'(32767);
		else if (v < -coord_t'(32768))
			r = -AX_W'(32767) - AX_W'(1);
		else
			r = v[AX_W-1:0];
		return r;
	endfunction

endpackage

// ----- design/vpt_vtx_if.sv -----
// Input word channel: loads and vertices.
interface vpt_vtx_if import vpt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ROW_W-1:0]    row_index;
	coord_t              comp_x;
	coord_t              comp_y;
	coord_t              comp_z;
	coord_t              origin;
	logic                batch_end;

	modport source (output valid, mode, row_index, comp_x, comp_y, comp_z, origin, batch_end,
		input ready);
	modport sink (input valid, mode, row_index, comp_x, comp_y, comp_z, origin, batch_end,
		output ready);
endinterface

// ----- design/vpt_res_if.sv -----
// Result word channel: projected vertex.
interface vpt_res_if import vpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic signed [31:0] depth;
	logic               last_out;

	modport source (output valid, screen_x, screen_y, depth, last_out, input ready);
	modport sink (input valid, screen_x, screen_y, depth, last_out, output ready);
endinterface

// ----- design/vpt_cfg_if.sv -----
// Configuration write channel: view_offset_x.
interface vpt_cfg_if import vpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OFS_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- design/vpt_compose.sv -----
// Composite matrix and offset vector, two pipeline stages.
module vpt_compose import vpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  axis_t  cam [9],
	input  axis_t  obj [9],
	input  coord_t cam_org [NROW],
	input  coord_t obj_org [NROW],
	input  coord_t c_in [NROW],
	input  logic   last_in,
	output logic   vld_s2,
	output fent_t  f_s2 [9],
	output addv_t  add_s2 [NROW],
	output coord_t c_s2 [NROW],
	output logic   last_s2
);

	logic signed [PF_W-1:0]  pf_s1 [9][NROW];
	logic signed [PA_W-1:0]  pa_s1 [NROW][NROW];
	logic signed [DIF_W-1:0] d [NROW];
	coord_t                  c_s1 [NROW];
	logic                    last_s1;
	logic                    vld_s1;

	always_comb begin
		for (int k = 0; k < NROW; k++)
			d[k] = DIF_W'(obj_org[k]) - DIF_W'(cam_org[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NROW; i++) begin
				for (int j = 0; j < NROW; j++)
					for (int k = 0; k < NROW; k++)
						pf_s1[i*3+j][k] <= cam[i*3+k] * obj[j*3+k];
				for (int k = 0; k < NROW; k++)
					pa_s1[i][k] <= d[k] * cam[i*3+k];
				c_s1[i] <= c_in[i];
			end
			last_s1 <= last_in;

			for (int e = 0; e < 9; e++)
				f_s2[e] <= F_W'(pf_s1[e][0]) + F_W'(pf_s1[e][1]) + F_W'(pf_s1[e][2]);
			for (int i = 0; i < NROW; i++) begin
				add_s2[i] <= ADD_W'(pa_s1[i][0]) + ADD_W'(pa_s1[i][1]) + ADD_W'(pa_s1[i][2]);
				c_s2[i]   <= c_s1[i];
			end
			last_s2 <= last_s1;
		end
	end

endmodule

// ----- design/vpt_xform.sv -----
// Vertex into view space, two pipeline stages.
module vpt_xform import vpt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  fent_t  f [9],
	input  addv_t  add [NROW],
	input  coord_t c [NROW],
	input  logic   last_in,
	output logic   vld_s4,
	output view_t  v_s4 [NROW],
	output logic   last_s4
);

	logic signed [ACC_W-1:0] pm_s3 [NROW][NROW];
	logic signed [ACC_W-1:0] pa_s3 [NROW];
	logic signed [ACC_W-1:0] acc [NROW];
	logic                    last_s3;
	logic                    vld_s3;

	always_comb begin
		for (int i = 0; i < NROW; i++)
			acc[i] = pa_s3[i] + pm_s3[i][0] + pm_s3[i][1] + pm_s3[i][2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_in;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NROW; i++) begin
				for (int j = 0; j < NROW; j++)
					pm_s3[i][j] <= f[i*3+j] * c[j];
				pa_s3[i] <= ACC_W'(add[i]) <<< AXIS_FRAC;
				v_s4[i]  <= acc[i][ACC_W-1:SHIFT];
			end
			last_s3 <= last_in;
			last_s4 <= last_s3;
		end
	end

endmodule

// ----- design/vpt_div.sv -----
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module vpt_div import vpt_pkg::*; #(
	parameter int NUM_W  = DIV_NUM_W,
	parameter int DEN_W  = DIV_DEN_W,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  num_s  [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];
	logic [DEN_W-1:0]  rem_n  [NUM_W];
	logic [NUM_W-1:0]  num_n  [NUM_W];

	always_comb begin
		logic [DEN_W-1:0] r_in;
		logic [NUM_W-1:0] n_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W:0]   t;
		logic [DEN_W:0]   diff;
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				r_in = '0;
				n_in = num;
				d_in = den;
			end else begin
				r_in = rem_s[k-1];
				n_in = num_s[k-1];
				d_in = den_s[k-1];
			end
			t    = {r_in, n_in[NUM_W-1]};
			diff = t - {1'b0, d_in};
			rem_n[k] = diff[DEN_W] ? t[DEN_W-1:0] : diff[DEN_W-1:0];
			num_n[k] = {n_in[NUM_W-2:0], ~diff[DEN_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int k = 1; k < NUM_W; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				rem_s[k] <= rem_n[k];
				num_s[k] <= num_n[k];
			end
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int k = 1; k < NUM_W; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vld_out  = vld_s[NUM_W-1];
	assign quo      = num_s[NUM_W-1];
	assign side_out = side_s[NUM_W-1];

endmodule

// ----- design/vertex_perspective_transform_unit.sv -----
// Vertex perspective transform unit: frame loads, view transform, projection, depth.
// Takes one word per cycle unless the result is stalled. A vertex word yields one result word; two
// stages build the composite matrix and offsets, two transform the vertex, one scales
// for projection, 52 divider stages (one quotient bit each) form the three quotients,
// and one register saturates. Load words update the frames at once and are seen by the
// very next vertex; they and mode three produce no result. A stalled result freezes the
// whole pipeline.
module vertex_perspective_transform_unit import vpt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	vpt_vtx_if.sink   vtx,
	vpt_res_if.source res,
	vpt_cfg_if.sink   cfg
);
	`include "vertex_perspective_transform_unit_macros.svh"

	localparam int NUM_W = DIV_NUM_W;
	localparam int DEN_W = DIV_DEN_W;
	localparam int SAT_W = NUM_W + 2;
	localparam logic signed [SAT_W-1:0] XY_MAX = SAT_W'(32767);
	localparam logic signed [SAT_W-1:0] XY_MIN = -SAT_W'(32768);
	localparam logic signed [NUM_W:0]   DEP_MAX = (NUM_W+1)'(2147483647);
	localparam logic signed [NUM_W:0]   DEP_MIN = -DEP_MAX - (NUM_W+1)'(1);
	localparam logic [NUM_W-1:0] DEP_NUM = NUM_W'(DEPTH_SCALE) << DEPTH_SHIFT;
	localparam view_t VZ_ONE = V_W'(1) <<< VZ_ONE_SH;

	logic             adv;
	logic [OFS_W-1:0] view_offset_q;
	axis_t            cam_q [9];
	axis_t            obj_q [9];
	coord_t           cam_org_q [NROW];
	coord_t           obj_org_q [NROW];
	coord_t           c_in [NROW];
	logic             is_vtx;
	logic             is_load;

	logic   vld_s2, last_s2, vld_s4, last_s4;
	fent_t  f_s2 [9];
	addv_t  add_s2 [NROW];
	coord_t c_s2 [NROW];
	view_t  v_s4 [NROW];

	view_t                   vzf;
	logic                    vld_s5, last_s5;
	logic signed [NUM_W-1:0] nx_s5, ny_s5;
	view_t                   vz_s5;
	logic [NUM_W-1:0]        mag_x, mag_y;
	logic [DEN_W-1:0]        mag_z;

	logic             vld_x, vld_y, vld_d;
	logic [NUM_W-1:0] quo_x, quo_y, quo_d;
	logic             sgn_x, sgn_y;
	logic [1:0]       side_d;

	logic signed [NUM_W:0]   qx, qy, qd;
	logic signed [SAT_W-1:0] sxw, syw;
	logic signed [15:0]      sx_n, sy_n;
	logic signed [31:0]      dep_n;
	logic                    vld_o_q, last_o_q;
	logic signed [15:0]      sx_q, sy_q;
	logic signed [31:0]      dep_q;

	assign adv       = !vld_o_q || res.ready;
	assign vtx.ready = adv;
	assign cfg.ready = 1'b1;
	assign is_vtx    = vtx.valid && (vtx.mode == MODE_VERTEX);
	assign is_load   = vtx.valid && adv
		&& ((vtx.mode == MODE_CAM) || (vtx.mode == MODE_OBJ));
	assign c_in[0]   = vtx.comp_x;
	assign c_in[1]   = vtx.comp_y;
	assign c_in[2]   = vtx.comp_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_offset_q <= VIEW_OFFSET_RESET;
		end else if (cfg.valid) begin
			view_offset_q <= cfg.data;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < 9; e++) begin
				cam_q[e] <= (e % 4 == 0) ? AXIS_ONE : '0;
				obj_q[e] <= (e % 4 == 0) ? AXIS_ONE : '0;
			end
			for (int r = 0; r < NROW; r++) begin
				cam_org_q[r] <= '0;
				obj_org_q[r] <= '0;
			end
		end else if (is_load) begin
			for (int r = 0; r < NROW; r++) begin
				if (vtx.row_index == ROW_W'(r)) begin
					for (int k = 0; k < NROW; k++) begin
						if (vtx.mode == MODE_CAM)
							cam_q[r*3+k] <= sat_axis(c_in[k]);
						else
							obj_q[r*3+k] <= sat_axis(c_in[k]);
					end
					if (vtx.mode == MODE_CAM)
						cam_org_q[r] <= vtx.origin;
					else
						obj_org_q[r] <= vtx.origin;
				end
			end
		end
	end

	vpt_compose u_compose (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (is_vtx),
		.cam     (cam_q),
		.obj     (obj_q),
		.cam_org (cam_org_q),
		.obj_org (obj_org_q),
		.c_in    (c_in),
		.last_in (vtx.batch_end),
		.vld_s2  (vld_s2),
		.f_s2    (f_s2),
		.add_s2  (add_s2),
		.c_s2    (c_s2),
		.last_s2 (last_s2)
	);

	vpt_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (vld_s2),
		.f       (f_s2),
		.add     (add_s2),
		.c       (c_s2),
		.last_in (last_s2),
		.vld_s4  (vld_s4),
		.v_s4    (v_s4),
		.last_s4 (last_s4)
	);

	// projection scaling, 640 = 512 + 128
	assign vzf = (v_s4[2] == '0) ? VZ_ONE : v_s4[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s5   <= (NUM_W'(v_s4[0]) <<< PROJ_SH_HI) + (NUM_W'(v_s4[0]) <<< PROJ_SH_LO);
			ny_s5   <= (NUM_W'(v_s4[1]) <<< PROJ_SH_HI) + (NUM_W'(v_s4[1]) <<< PROJ_SH_LO);
			vz_s5   <= vzf;
			last_s5 <= last_s4;
		end
	end

	assign mag_x = nx_s5[NUM_W-1] ? NUM_W'(-nx_s5) : NUM_W'(nx_s5);
	assign mag_y = ny_s5[NUM_W-1] ? NUM_W'(-ny_s5) : NUM_W'(ny_s5);
	assign mag_z = vz_s5[V_W-1] ? DEN_W'(-vz_s5) : DEN_W'(vz_s5);

	vpt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s5),
		.num      (mag_x),
		.den      (mag_z),
		.side_in  (nx_s5[NUM_W-1] ^ vz_s5[V_W-1]),
		.vld_out  (vld_x),
		.quo      (quo_x),
		.side_out (sgn_x)
	);

	vpt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s5),
		.num      (mag_y),
		.den      (mag_z),
		.side_in  (ny_s5[NUM_W-1] ^ vz_s5[V_W-1]),
		.vld_out  (vld_y),
		.quo      (quo_y),
		.side_out (sgn_y)
	);

	vpt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(2)) u_div_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s5),
		.num      (DEP_NUM),
		.den      (mag_z),
		.side_in  ({last_s5, vz_s5[V_W-1]}),
		.vld_out  (vld_d),
		.quo      (quo_d),
		.side_out (side_d)
	);

	// sign restore and saturation
	always_comb begin
		qx = sgn_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
		qy = sgn_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
		qd = side_d[0] ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
		sxw = $signed({{(SAT_W-OFS_W){1'b0}}, view_offset_q}) - SAT_W'(qx);
		syw = SAT_W'(SCREEN_Y_CENTRE) + SAT_W'(qy);
		if (sxw > XY_MAX)
			sx_n = XY_MAX[15:0];
		else if (sxw < XY_MIN)
			sx_n = XY_MIN[15:0];
		else
			sx_n = sxw[15:0];
		if (syw > XY_MAX)
			sy_n = XY_MAX[15:0];
		else if (syw < XY_MIN)
			sy_n = XY_MIN[15:0];
		else
			sy_n = syw[15:0];
		if (qd > DEP_MAX)
			dep_n = DEP_MAX[31:0];
		else if (qd < DEP_MIN)
			dep_n = DEP_MIN[31:0];
		else
			dep_n = qd[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (adv) begin
			vld_o_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q     <= sx_n;
			sy_q     <= sy_n;
			dep_q    <= dep_n;
			last_o_q <= side_d[1];
		end
	end

	assign res.valid    = vld_o_q;
	assign res.screen_x = sx_q;
	assign res.screen_y = sy_q;
	assign res.depth    = dep_q;
	assign res.last_out = last_o_q;

	`VPT_ASSERT(a_div_lockstep, (vld_x == vld_y) && (vld_x == vld_d), "divider lanes out of step")
	`VPT_ASSERT(a_vz_nonzero, !vld_s5 || (vz_s5 != '0), "zero divisor entered the divider")
	`VPT_ASSERT_NEXT(a_stall_holds, !adv, vld_s5 == $past(vld_s5), "pipeline moved during stall")

endmodule

// ----- verif/vpt_tb_if.sv -----
// Word types shared by the vertex perspective transform testbench.
`timescale 1ns / 100ps
package vpt_tb_types;
	import vpt_pkg::*;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [ROW_W-1:0]  row_index;
		coord_t            comp_x;
		coord_t            comp_y;
		coord_t            comp_z;
		coord_t            origin;
		logic              batch_end;
	} vtx_word_t;

	typedef struct {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic signed [31:0] depth;
		logic               last_out;
	} proj_word_t;
endpackage

// ----- verif/vertex_perspective_transform_unit_tb.sv -----
// Testbench of the vertex perspective transform unit: self-checking against its own predictor.
`timescale 1ns / 100ps
module vertex_perspective_transform_unit_tb;
	import vpt_pkg::*;
	import vpt_tb_types::*;

	localparam int LATENCY = 58;

	logic clk;
	logic arst_n;

	vpt_vtx_if vtx ();
	vpt_res_if res ();
	vpt_cfg_if cfg ();

	vertex_perspective_transform_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	vtx_word_t  pending_words[$];
	proj_word_t expected_proj[$];
	int         errors;
	logic       offering;
	int         vtx_gap;
	int         res_gap;
	int         hold_cycles;
	logic       hold_req;

	longint cam_ax[9];
	longint obj_ax[9];
	longint cam_org[3];
	longint obj_org[3];
	longint offset_x;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint floor_sh16(longint x);
		if (x >= 0)
			return x >>> 16;
		return -((-x - 1) >>> 16) - 1;
	endfunction

	task automatic frame_reset();
		for (int i = 0; i < 9; i++) begin
			cam_ax[i] = (i % 4 == 0) ? 16384 : 0;
			obj_ax[i] = cam_ax[i];
		end
		for (int i = 0; i < 3; i++) begin
			cam_org[i] = 0;
			obj_org[i] = 0;
		end
		offset_x = 320;
	endtask

	task automatic project_word(input vtx_word_t w);
		longint c[3];
		longint f[3][3];
		longint addv[3];
		longint v[3];
		longint acc;
		longint vz;
		longint qx;
		longint qy;
		proj_word_t p;
		c[0] = w.comp_x;
		c[1] = w.comp_y;
		c[2] = w.comp_z;
		if (w.mode == MODE_CAM || w.mode == MODE_OBJ) begin
			if (w.row_index < 3) begin
				for (int k = 0; k < 3; k++) begin
					if (w.mode == MODE_OBJ)
						obj_ax[w.row_index*3+k] = clip(c[k], -32768, 32767);
					else
						cam_ax[w.row_index*3+k] = clip(c[k], -32768, 32767);
				end
				if (w.mode == MODE_OBJ)
					obj_org[w.row_index] = w.origin;
				else
					cam_org[w.row_index] = w.origin;
			end
			return;
		end
		if (w.mode == MODE_IGNORE)
			return;
		for (int i = 0; i < 3; i++) begin
			addv[i] = 0;
			for (int k = 0; k < 3; k++)
				addv[i] += (obj_org[k] - cam_org[k]) * cam_ax[i*3+k];
			for (int j = 0; j < 3; j++) begin
				f[i][j] = 0;
				for (int k = 0; k < 3; k++)
					f[i][j] += cam_ax[i*3+k] * obj_ax[j*3+k];
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = addv[i] * 16384;
			for (int j = 0; j < 3; j++)
				acc += f[i][j] * c[j];
			v[i] = floor_sh16(acc);
		end
		vz = v[2] == 0 ? (longint'(1) << 20) : v[2];
		qx = (v[0] * 640) / vz;
		qy = (v[1] * 640) / vz;
		p.screen_x = 16'(clip(offset_x - qx, -32768, 32767));
		p.screen_y = 16'(clip(240 + qy, -32768, 32767));
		p.depth = 32'(clip((longint'(10) << 36) / vz, -(longint'(1) << 31),
			(longint'(1) << 31) - 1));
		p.last_out = w.batch_end;
		expected_proj.push_back(p);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return -coord_t'(8388608);
			2: return coord_t'(8388607);
			default: return coord_t'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
		endcase
	endfunction

	function automatic coord_t rnd_axis();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 32768)) - 16384);
			default: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
		endcase
	endfunction

	function automatic vtx_word_t mk(logic [MODE_W-1:0] m, logic [ROW_W-1:0] r, coord_t x,
		coord_t y, coord_t z, coord_t o, logic b);
		vtx_word_t w;
		w.mode = m;
		w.row_index = r;
		w.comp_x = x;
		w.comp_y = y;
		w.comp_z = z;
		w.origin = o;
		w.batch_end = b;
		return w;
	endfunction

	function automatic vtx_word_t rnd_vertex();
		return mk(MODE_VERTEX, ROW_W'($urandom), rnd_coord(), rnd_coord(), rnd_coord(),
			coord_t'($urandom), 1'($urandom));
	endfunction

	function automatic vtx_word_t rnd_load();
		logic [MODE_W-1:0] m;
		m = $urandom_range(0, 1) ? MODE_OBJ : MODE_CAM;
		return mk(m, ROW_W'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
			rnd_axis(), rnd_axis(), rnd_axis(), rnd_coord(), 1'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_words.size() != 0 || offering || expected_proj.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OFS_W-1:0] val);
		cfg.data <= val;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		offset_x = val;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			offering <= 1'b0;
			vtx_gap <= 0;
		end else begin
			if (offering && !(vtx.valid && vtx.ready)) begin
			end else if (vtx_gap > 0) begin
				vtx.valid <= 1'b0;
				offering <= 1'b0;
				vtx_gap <= vtx_gap - 1;
			end else if (pending_words.size() != 0) begin
				vtx_word_t w;
				w = pending_words.pop_front();
				project_word(w);
				vtx.mode <= w.mode;
				vtx.row_index <= w.row_index;
				vtx.comp_x <= w.comp_x;
				vtx.comp_y <= w.comp_y;
				vtx.comp_z <= w.comp_z;
				vtx.origin <= w.origin;
				vtx.batch_end <= w.batch_end;
				vtx.valid <= 1'b1;
				offering <= 1'b1;
				vtx_gap <= pick_gap();
			end else begin
				vtx.valid <= 1'b0;
				offering <= 1'b0;
			end
		end
	end

	// monitor and result-side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_gap <= 0;
			hold_cycles <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_proj.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%0d y=%0d d=%0d", $time,
						res.screen_x, res.screen_y, res.depth);
				end else begin
					proj_word_t e;
					e = expected_proj.pop_front();
					if (e.screen_x !== res.screen_x || e.screen_y !== res.screen_y ||
						e.depth !== res.depth || e.last_out !== res.last_out) begin
						errors++;
						$display("%0t: mismatch exp x=%0d y=%0d d=%0d l=%0b got x=%0d y=%0d d=%0d l=%0b",
							$time, e.screen_x, e.screen_y, e.depth, e.last_out,
							res.screen_x, res.screen_y, res.depth, res.last_out);
					end
				end
			end
			if (hold_req && hold_cycles == 0) begin
				hold_cycles <= 300;
				res.ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				res.ready <= hold_cycles == 1;
			end else if (res_gap > 0) begin
				res_gap <= res_gap - 1;
				res.ready <= res_gap == 1;
			end else if ($urandom_range(0, 3) == 0) begin
				res_gap <= pick_gap();
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [OFS_W-1:0] offsets[4];
		errors = 0;
		hold_req = 1'b0;
		frame_reset();
		vtx.valid = 1'b0;
		vtx.mode = MODE_IGNORE;
		vtx.row_index = '0;
		vtx.comp_x = '0;
		vtx.comp_y = '0;
		vtx.comp_z = '0;
		vtx.origin = '0;
		vtx.batch_end = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity frames: extremes, zero depth, negative depth
		pending_words.push_back(mk(MODE_VERTEX, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(MODE_VERTEX, 3, 24'sd256, -24'sd256, 24'sd256, 0, 1));
		pending_words.push_back(mk(MODE_VERTEX, 0, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 0, 0));
		pending_words.push_back(mk(MODE_VERTEX, 0, 24'sh800000, 24'sh7FFFFF, -24'sd1, 0, 1));
		pending_words.push_back(mk(MODE_VERTEX, 1, 24'sd1000, 24'sd500, -24'sd2560, 0, 0));
		pending_words.push_back(mk(MODE_VERTEX, 2, 24'sd1, 24'sd1, 24'sh7FFFFF, 0, 1));
		pending_words.push_back(mk(MODE_IGNORE, 1, 24'sd5, 24'sd5, 24'sd5, 24'sd5, 1));
		// axis saturation both ways, origins at extremes
		pending_words.push_back(mk(MODE_CAM, 0, 24'sh7FFFFF, 24'sh800000, 0, 24'sh7FFFFF, 1));
		pending_words.push_back(mk(MODE_OBJ, 2, 24'sd40000, -24'sd40000, 24'sd16384,
			24'sh800000, 0));
		pending_words.push_back(mk(MODE_VERTEX, 0, 24'sd256, 24'sd256, 24'sd256, 0, 0));
		pending_words.push_back(mk(MODE_CAM, 3, 24'sd1, 24'sd1, 24'sd1, 24'sd77, 0));
		pending_words.push_back(mk(MODE_OBJ, 3, 24'sd1, 24'sd1, 24'sd1, 24'sd77, 1));
		pending_words.push_back(mk(MODE_VERTEX, 1, -24'sd256, 24'sd512, 24'sd1024, 0, 1));
		pending_words.push_back(mk(MODE_CAM, 0, 24'sd16384, 0, 0, 0, 0));
		pending_words.push_back(mk(MODE_OBJ, 2, 0, 0, 24'sd16384, 0, 0));
		pending_words.push_back(mk(MODE_CAM, 2, 0, 0, -24'sd16384, 24'sd2560, 0));
		pending_words.push_back(mk(MODE_VERTEX, 0, 24'sd3000, -24'sd3000, 24'sd256, 0, 1));
		pending_words.push_back(mk(MODE_CAM, 2, 0, 0, 24'sd16384, 0, 0));
		wait_drained();

		offsets[0] = '0;
		offsets[1] = '1;
		offsets[2] = 12'd640;
		offsets[3] = VIEW_OFFSET_RESET;
		for (int ph = 0; ph < 4; ph++) begin
			write_offset(offsets[ph] ^ (ph == 2 ? 12'($urandom) & 12'h0FF : 12'h000));
			for (int n = 0; n < 235; n++) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70)
					pending_words.push_back(rnd_vertex());
				else if (r < 95)
					pending_words.push_back(rnd_load());
				else
					pending_words.push_back(mk(MODE_IGNORE, ROW_W'($urandom), rnd_coord(),
						rnd_coord(), rnd_coord(), coord_t'($urandom), 1'($urandom)));
			end
			if (ph == 1) begin
				hold_req = 1'b1;
				wait (hold_cycles != 0);
				hold_req = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- vertex_perspective_transform_unit.f -----
+incdir+design
design/vpt_pkg.sv
design/vpt_vtx_if.sv
design/vpt_res_if.sv
design/vpt_cfg_if.sv
design/vpt_compose.sv
design/vpt_xform.sv
design/vpt_div.sv
design/vertex_perspective_transform_unit.sv
verif/vpt_tb_if.sv
verif/vertex_perspective_transform_unit_tb.sv
